// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the CAN line reassembler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CLR_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define CLR_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hdl/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Types and constants shared by the CAN line reassembler modules.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int ID_W   = 29;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int BYTE_W = 8;

    localparam logic [LEN_W-1:0]  MAX_LEN   = 4'd8;
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_LO_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LO_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_MASK = 8'hDF;

    typedef struct packed {
        logic load_frame;
        logic bind_slot;
        logic emit_drop;
        logic byte_next;
        logic byte_append;
        logic byte_newline;
        logic pend_load;
        logic out_pend;
        logic out_marker;
    } clr_cmd_t;

    typedef struct packed {
        logic hit;
        logic vacant;
        logic frame_done;
        logic is_cr;
        logic is_lf;
        logic stop;
        logic out_free;
    } clr_sts_t;

endpackage

// File: hdl/clr_in_if.sv
// ----------------------------------------------------------------------------
// clr_in_if
// Frame channel: valid/ready handshake with the received CAN frame payload.
// ----------------------------------------------------------------------------
interface clr_in_if import clr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   sender_id;
    logic [LEN_W-1:0]  frame_length;
    logic [DATA_W-1:0] frame_data;

    modport source (output valid, output sender_id, output frame_length,
                    output frame_data, input ready);
    modport sink   (input valid, input sender_id, input frame_length,
                    input frame_data, output ready);

endinterface

// File: hdl/clr_out_if.sv
// ----------------------------------------------------------------------------
// clr_out_if
// Line channel: valid/ready handshake with one line character or marker.
// ----------------------------------------------------------------------------
interface clr_out_if import clr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              status;
    logic [ID_W-1:0]   source_id;
    logic              has_byte;
    logic [BYTE_W-1:0] line_byte;
    logic              end_of_line;

    modport source (output valid, output status, output source_id, output has_byte,
                    output line_byte, output end_of_line, input ready);
    modport sink   (input valid, input status, input source_id, input has_byte,
                    input line_byte, input end_of_line, output ready);

endinterface

// File: hdl/clr_ram.sv
// ----------------------------------------------------------------------------
// clr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/clr_datapath.sv
// ----------------------------------------------------------------------------
// clr_datapath
// Slot table, frame registers, line store and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clr_datapath import clr_pkg::*; #(
    parameter int SLOTS      = 4,
    parameter int LINE_BYTES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  clr_cmd_t          cmd,
    output clr_sts_t          sts,
    input  logic [ID_W-1:0]   in_sender_id,
    input  logic [LEN_W-1:0]  in_frame_length,
    input  logic [DATA_W-1:0] in_frame_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              out_status,
    output logic [ID_W-1:0]   out_source_id,
    output logic              out_has_byte,
    output logic [BYTE_W-1:0] out_line_byte,
    output logic              out_end_of_line
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(LINE_BYTES + 1);
    localparam int DEPTH  = SLOTS * LINE_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              busy_reg   [SLOTS];
    logic [ID_W-1:0]   sender_reg [SLOTS];
    logic [FILL_W-1:0] fill_reg   [SLOTS];

    logic [ID_W-1:0]   id_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [DATA_W-1:0] data_reg;
    logic [LEN_W-1:0]  j_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [FILL_W-1:0] emit_fill_reg;
    logic [FILL_W-1:0] rd_ptr_reg;
    logic [FILL_W-1:0] rd_ptr_next;
    logic [BYTE_W-1:0] pend_reg;

    logic              out_valid_reg;
    logic              out_status_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_hb_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_eol_reg;

    logic              hit;
    logic              vacant;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] bind_idx;
    logic [BYTE_W-1:0] raw_char;
    logic [BYTE_W-1:0] up_char;
    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] fill_eff;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              stop;
    logic              out_free;
    logic              out_load;

    // lowest matching slot, lowest free slot
    always_comb
    begin
        hit      = 1'b0;
        vacant   = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (busy_reg[i] && (sender_reg[i] == id_reg))
            begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!busy_reg[i])
            begin
                vacant   = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign bind_idx = hit ? hit_idx : free_idx;

    always_comb
    begin
        raw_char = data_reg[{j_reg[2:0], 3'b000} +: BYTE_W];
        if (raw_char inside {[CHAR_LO_A:CHAR_LO_Z]})
        begin
            up_char = raw_char & CASE_MASK;
        end
        else
        begin
            up_char = raw_char;
        end
    end

    assign fill_cur = fill_reg[slot_reg];
    assign fill_eff = (fill_cur >= FILL_W'(LINE_BYTES)) ? '0 : fill_cur;
    assign base     = ADDR_W'(ADDR_W'(slot_reg) * ADDR_W'(LINE_BYTES));
    assign wr_addr  = base + ADDR_W'(fill_eff);

    always_comb
    begin
        if (cmd.byte_newline)
        begin
            rd_ptr_next = '0;
        end
        else if (cmd.pend_load)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        else
        begin
            rd_ptr_next = rd_ptr_reg;
        end
    end

    assign rd_addr = base + ADDR_W'(rd_ptr_next);

    clr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.byte_append),
        .waddr (wr_addr),
        .wdata (up_char),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign stop     = (rd_ptr_reg == emit_fill_reg) || (rd_data == '0);
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = cmd.emit_drop || cmd.out_marker || cmd.out_pend;

    assign sts.hit        = hit;
    assign sts.vacant     = vacant;
    assign sts.frame_done = (j_reg == len_reg);
    assign sts.is_cr      = (raw_char == CHAR_CR);
    assign sts.is_lf      = (up_char == CHAR_LF);
    assign sts.stop       = stop;
    assign sts.out_free   = out_free;

    // slot table and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                busy_reg[i] <= 1'b0;
                fill_reg[i] <= '0;
            end
            j_reg         <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            if (cmd.load_frame)
            begin
                j_reg <= '0;
            end
            else if (cmd.byte_next)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (cmd.bind_slot && !hit)
            begin
                busy_reg[free_idx] <= 1'b1;
                fill_reg[free_idx] <= '0;
            end
            if (cmd.byte_append)
            begin
                fill_reg[slot_reg] <= FILL_W'(fill_eff + 1'b1);
            end
            if (cmd.byte_newline)
            begin
                fill_reg[slot_reg] <= '0;
                if ((j_reg + 1'b1) == len_reg)
                begin
                    busy_reg[slot_reg] <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_frame)
        begin
            id_reg   <= in_sender_id;
            len_reg  <= (in_frame_length > MAX_LEN) ? MAX_LEN : in_frame_length;
            data_reg <= in_frame_data;
        end
        if (cmd.bind_slot)
        begin
            slot_reg <= bind_idx;
            if (!hit)
            begin
                sender_reg[free_idx] <= id_reg;
            end
        end
        if (cmd.byte_newline)
        begin
            emit_fill_reg <= fill_eff;
        end
        if (cmd.pend_load)
        begin
            pend_reg <= rd_data;
        end
        if (out_load)
        begin
            out_status_reg <= cmd.emit_drop;
            out_id_reg     <= id_reg;
            out_hb_reg     <= cmd.out_pend;
            out_byte_reg   <= cmd.out_pend ? pend_reg : '0;
            out_eol_reg    <= cmd.out_pend ? stop : 1'b1;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_source_id   = out_id_reg;
    assign out_has_byte    = out_hb_reg;
    assign out_line_byte   = out_byte_reg;
    assign out_end_of_line = out_eol_reg;

    `CLR_CHECK(a_bind_has_slot, clk, rst_n, cmd.bind_slot |-> (hit || vacant), "bind without slot")
    `CLR_CHECK(a_bound_busy, clk, rst_n, cmd.bind_slot |=> busy_reg[slot_reg], "bound slot not busy")
    `CLR_NEVER(a_load_over_full, clk, rst_n, out_load && !out_free, "output overwritten")

endmodule

// File: hdl/clr_ctrl.sv
// ----------------------------------------------------------------------------
// clr_ctrl
// Sequencer: frame accept, slot lookup, per-byte processing, line emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clr_ctrl import clr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output clr_cmd_t cmd,
    input  clr_sts_t sts
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_LOOKUP     = 3'd1;
    localparam logic [2:0] S_BYTE       = 3'd2;
    localparam logic [2:0] S_EMIT_FIRST = 3'd3;
    localparam logic [2:0] S_EMIT_RUN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (sts.hit || sts.vacant)
                begin
                    cmd.bind_slot = 1'b1;
                    state_next    = S_BYTE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_drop = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_BYTE:
            begin
                if (sts.frame_done)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.is_cr)
                begin
                    cmd.byte_next = 1'b1;
                end
                else if (!sts.is_lf)
                begin
                    cmd.byte_append = 1'b1;
                    cmd.byte_next   = 1'b1;
                end
                else
                begin
                    cmd.byte_newline = 1'b1;
                    cmd.byte_next    = 1'b1;
                    state_next       = S_EMIT_FIRST;
                end
            end
            S_EMIT_FIRST:
            begin
                if (!sts.stop)
                begin
                    cmd.pend_load = 1'b1;
                    state_next    = S_EMIT_RUN;
                end
                else if (sts.out_free)
                begin
                    cmd.out_marker = 1'b1;
                    state_next     = S_BYTE;
                end
            end
            S_EMIT_RUN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_pend = 1'b1;
                    if (sts.stop)
                    begin
                        state_next = S_BYTE;
                    end
                    else
                    begin
                        cmd.pend_load = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CLR_CHECK(a_lookup_entry, clk, rst_n, (state_reg == S_LOOKUP && $past(state_reg) != S_LOOKUP) |-> $past(state_reg) == S_IDLE, "lookup not after accept")
    `CLR_CHECK(a_first_entry, clk, rst_n, (state_reg == S_EMIT_FIRST) |-> ($past(state_reg) == S_BYTE || $past(state_reg) == S_EMIT_FIRST), "emission not after newline")

endmodule

// File: hdl/can_line_reassembler.sv
// ----------------------------------------------------------------------------
// can_line_reassembler
// Collects text lines per CAN sender and emits each completed line per byte.
//
//   channel   dir   handshake      beat
//   in_ch     in    valid/ready    one CAN frame: sender_id, frame_length, data
//   out_ch    out   valid/ready    one line character, empty marker or drop
//
// One frame at a time, in steps: accept, slot lookup, then each data byte in turn,
// plus per newline a read of the line store and then each emitted character
// (an empty-line marker leaves in the read step), then back to idle (a dropped
// frame returns to idle straight from the lookup).
// The line store read port sets the one-character-per-cycle emission rate while out_ch is ready.
// Reset clears the slot table at once; the line store needs no clearing.
// A stalled out_ch holds the sequencer; out_ch has one output register.
// ----------------------------------------------------------------------------
module can_line_reassembler import clr_pkg::*; #(
    parameter int SLOTS      = 4,
    parameter int LINE_BYTES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    clr_in_if.sink     in_ch,
    clr_out_if.source  out_ch
);

    clr_cmd_t cmd;
    clr_sts_t sts;

    clr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    clr_datapath #(
        .SLOTS      (SLOTS),
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_sender_id    (in_ch.sender_id),
        .in_frame_length (in_ch.frame_length),
        .in_frame_data   (in_ch.frame_data),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_status      (out_ch.status),
        .out_source_id   (out_ch.source_id),
        .out_has_byte    (out_ch.has_byte),
        .out_line_byte   (out_ch.line_byte),
        .out_end_of_line (out_ch.end_of_line)
    );

endmodule
